/* rtl/core/assert_macros.svh */
// concurrent assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

/* rtl/core/prras_pkg.sv */
package prras_pkg;

   localparam int STAMP_W = 32;

   localparam logic [7:0] QUANTUM_RST = 8'd10;
   localparam logic [3:0] CAP_RST     = 4'd10;
   localparam logic [3:0] REINS_PRIO  = 4'd1;

   typedef enum logic {
      ACT_ADD  = 1'b0,
      ACT_PICK = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic {
      REG_QUANTUM = 1'b0,
      REG_CAP     = 1'b1
   } reg_index_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_SCAN,
      B_EXEC
   } back_state_type;

   typedef struct packed {
      logic        action;
      logic [3:0]  priority_req;
      logic [15:0] burst;
   } req_word_type;

   typedef struct packed {
      logic [7:0]  task_id;
      logic [7:0]  run_length;
      logic        finished;
      logic [1:0]  status;
      logic [31:0] elapsed_time;
   } rsp_word_type;

   typedef struct packed {
      logic idle;
      logic overfull;
   } back_status_type;

endpackage

/* rtl/core/prras_front.sv */
module prras_front
   import prras_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  req_word_type req_word,
   output logic         busy,
   output logic         q_valid,
   output req_word_type q_word,
   input  logic         q_pop
);

   req_word_type slot_ff [2];
   req_word_type slot_in [2];
   logic [1:0] fill_ff, fill_in;
   logic       push;

   assign busy    = (fill_ff == 2'd2);
   assign push    = start && !busy;
   assign q_valid = (fill_ff != 2'd0);
   assign q_word  = slot_ff[0];

   always_comb begin
      slot_in = slot_ff;
      fill_in = fill_ff;
      if (q_pop && q_valid) begin
         slot_in[0] = slot_ff[1];
         fill_in    = fill_in - 2'd1;
      end
      if (push) begin
         slot_in[fill_in[0]] = req_word;
         fill_in = fill_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (reset) begin
         fill_ff <= 2'd0;
      end else begin
         fill_ff <= fill_in;
      end
   end

endmodule

/* rtl/core/prras_back.sv */
module prras_back
   import prras_pkg::*;
#(
   parameter int MAX_TASKS   = 32,
   parameter int BURST_WIDTH = 16
)(
   input  logic            clock,
   input  logic            reset,
   input  logic [7:0]      quantum,
   input  logic [3:0]      priority_cap,
   input  logic            q_valid,
   input  req_word_type    q_word,
   output logic            q_pop,
   output logic            rsp_valid,
   output rsp_word_type    rsp_word,
   output back_status_type stat
);

   localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CNT_W = $clog2(MAX_TASKS + 1);
   localparam int CW    = (BURST_WIDTH > 8) ? BURST_WIDTH : 8;

   logic [7:0]             mem_id    [MAX_TASKS];
   logic [3:0]             mem_prio  [MAX_TASKS];
   logic [BURST_WIDTH-1:0] mem_burst [MAX_TASKS];
   logic [STAMP_W-1:0]     mem_stamp [MAX_TASKS];

   logic [7:0]             rd_id;
   logic [3:0]             rd_prio;
   logic [BURST_WIDTH-1:0] rd_burst;
   logic [STAMP_W-1:0]     rd_stamp;

   logic                   we;
   logic [IDX_W-1:0]       wa;
   logic [7:0]             wd_id;
   logic [3:0]             wd_prio;
   logic [BURST_WIDTH-1:0] wd_burst;
   logic [STAMP_W-1:0]     wd_stamp;

   back_state_type state_ff, state_in;
   logic [CNT_W-1:0]       ra_ff, ra_in;
   logic                   rv_ff, rv_in;
   logic [IDX_W-1:0]       da_ff, da_in;
   logic                   hb_ff, hb_in;
   logic [IDX_W-1:0]       bi_ff, bi_in;
   logic [7:0]             bid_ff, bid_in;
   logic [3:0]             bpr_ff, bpr_in;
   logic [BURST_WIDTH-1:0] bb_ff, bb_in;
   logic [STAMP_W-1:0]     bst_ff, bst_in;
   logic [7:0]             lid_ff, lid_in;
   logic [3:0]             lpr_ff, lpr_in;
   logic [BURST_WIDTH-1:0] lb_ff, lb_in;
   logic [STAMP_W-1:0]     lst_ff, lst_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [7:0]             nid_ff, nid_in;
   logic [31:0]            time_ff, time_in;
   logic [STAMP_W-1:0]     stamp_ff, stamp_in;
   logic                   rv_o_ff, rv_o_in;
   rsp_word_type           rw_ff, rw_in;

   logic [3:0]             aged;
   logic                   take;
   logic                   scan_done;
   logic [CW-1:0]          b_ext, q_ext;
   logic [7:0]             run;
   logic [32:0]            sum;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_id[wa]    <= wd_id;
         mem_prio[wa]  <= wd_prio;
         mem_burst[wa] <= wd_burst;
         mem_stamp[wa] <= wd_stamp;
      end
      rd_id    <= mem_id[ra_ff[IDX_W-1:0]];
      rd_prio  <= mem_prio[ra_ff[IDX_W-1:0]];
      rd_burst <= mem_burst[ra_ff[IDX_W-1:0]];
      rd_stamp <= mem_stamp[ra_ff[IDX_W-1:0]];
   end

   assign aged = (rd_prio < priority_cap) ? rd_prio + 4'd1 : rd_prio;
   assign take = !hb_ff || (aged > bpr_ff) || ((aged == bpr_ff) && (rd_stamp > bst_ff));
   assign scan_done = (ra_ff == cnt_ff) && !rv_ff;
   assign b_ext = CW'(bb_ff);
   assign q_ext = CW'(quantum);
   assign run   = (b_ext < q_ext) ? b_ext[7:0] : quantum;
   assign sum   = {1'b0, time_ff} + 33'(run);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE: begin
            if (q_valid && q_word.action == ACT_PICK) begin
               state_in = (cnt_ff == '0) ? B_EXEC : B_SCAN;
            end
         end
         B_SCAN: begin
            if (scan_done) begin
               state_in = B_EXEC;
            end
         end
         B_EXEC:  state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   always_comb begin
      q_pop    = 1'b0;
      we       = 1'b0;
      wa       = da_ff;
      wd_id    = rd_id;
      wd_prio  = aged;
      wd_burst = rd_burst;
      wd_stamp = rd_stamp;
      ra_in    = ra_ff;
      rv_in    = 1'b0;
      da_in    = ra_ff[IDX_W-1:0];
      hb_in    = hb_ff;
      bi_in    = bi_ff;
      bid_in   = bid_ff;
      bpr_in   = bpr_ff;
      bb_in    = bb_ff;
      bst_in   = bst_ff;
      lid_in   = lid_ff;
      lpr_in   = lpr_ff;
      lb_in    = lb_ff;
      lst_in   = lst_ff;
      cnt_in   = cnt_ff;
      nid_in   = nid_ff;
      time_in  = time_ff;
      stamp_in = stamp_ff;
      rv_o_in  = 1'b0;
      rw_in    = '0;
      rw_in.elapsed_time = time_ff;
      case (state_ff)
         B_IDLE: begin
            ra_in = '0;
            hb_in = 1'b0;
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_word.action == ACT_ADD) begin
                  rv_o_in = 1'b1;
                  if (cnt_ff == CNT_W'(MAX_TASKS)) begin
                     rw_in.status = ST_FULL;
                  end else begin
                     we       = 1'b1;
                     wa       = cnt_ff[IDX_W-1:0];
                     wd_id    = nid_ff;
                     wd_prio  = q_word.priority_req;
                     wd_burst = BURST_WIDTH'(q_word.burst);
                     wd_stamp = stamp_ff;
                     stamp_in = stamp_ff + 1'b1;
                     cnt_in   = cnt_ff + 1'b1;
                     nid_in   = nid_ff + 8'd1;
                     rw_in.task_id = nid_ff;
                  end
               end
            end
         end
         B_SCAN: begin
            if (ra_ff != cnt_ff) begin
               ra_in = ra_ff + 1'b1;
               rv_in = 1'b1;
            end
            if (rv_ff) begin
               we = 1'b1;
               if (take) begin
                  hb_in  = 1'b1;
                  bi_in  = da_ff;
                  bid_in = rd_id;
                  bpr_in = aged;
                  bb_in  = rd_burst;
                  bst_in = rd_stamp;
               end
               if (CNT_W'(da_ff) == cnt_ff - 1'b1) begin
                  lid_in = rd_id;
                  lpr_in = aged;
                  lb_in  = rd_burst;
                  lst_in = rd_stamp;
               end
            end
         end
         B_EXEC: begin
            rv_o_in = 1'b1;
            if (cnt_ff == '0) begin
               rw_in.status = ST_EMPTY;
            end else begin
               time_in = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
               rw_in.elapsed_time = time_in;
               rw_in.task_id    = bid_ff;
               rw_in.run_length = run;
               wa = bi_ff;
               we = 1'b1;
               if (b_ext > q_ext) begin
                  wd_id    = bid_ff;
                  wd_prio  = REINS_PRIO;
                  wd_burst = BURST_WIDTH'(b_ext - q_ext);
                  wd_stamp = stamp_ff;
                  stamp_in = stamp_ff + 1'b1;
               end else begin
                  rw_in.finished = 1'b1;
                  wd_id    = lid_ff;
                  wd_prio  = lpr_ff;
                  wd_burst = lb_ff;
                  wd_stamp = lst_ff;
                  cnt_in   = cnt_ff - 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      da_ff  <= da_in;
      bi_ff  <= bi_in;
      bid_ff <= bid_in;
      bpr_ff <= bpr_in;
      bb_ff  <= bb_in;
      bst_ff <= bst_in;
      lid_ff <= lid_in;
      lpr_ff <= lpr_in;
      lb_ff  <= lb_in;
      lst_ff <= lst_in;
      rw_ff  <= rw_in;
      if (reset) begin
         state_ff <= B_IDLE;
         ra_ff    <= '0;
         rv_ff    <= 1'b0;
         hb_ff    <= 1'b0;
         cnt_ff   <= '0;
         nid_ff   <= '0;
         time_ff  <= '0;
         stamp_ff <= '0;
         rv_o_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         ra_ff    <= ra_in;
         rv_ff    <= rv_in;
         hb_ff    <= hb_in;
         cnt_ff   <= cnt_in;
         nid_ff   <= nid_in;
         time_ff  <= time_in;
         stamp_ff <= stamp_in;
         rv_o_ff  <= rv_o_in;
      end
   end

   assign rsp_valid     = rv_o_ff;
   assign rsp_word      = rw_ff;
   assign stat.idle     = (state_ff == B_IDLE);
   assign stat.overfull = (cnt_ff > CNT_W'(MAX_TASKS));

endmodule

/* rtl/core/priority_round_robin_aging_scheduler.sv */
// Add: the word passes the input queue; the back end writes it and registers the result.
// Pick: the back end scans the N stored tasks, then executes, or executes at once on an
// empty table; one entry is read, aged and compared per cycle through one table read port.
// A two-word input queue lets start be taken while the back end works; the back end takes
// an add word every cycle while idle, none during a pick. Results are strobed for one
// cycle, the receiver cannot stall. Synchronous reset empties table and queue, clears time.
module priority_round_robin_aging_scheduler
   import prras_pkg::*;
#(
   parameter int MAX_TASKS   = 32,
   parameter int BURST_WIDTH = 16
)(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_word_type req_word,
   output logic         rsp_valid,
   output rsp_word_type rsp_word,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [2:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

`include "assert_macros.svh"

   logic [7:0]      quantum_ff;
   logic [3:0]      cap_ff;
   logic            q_valid, q_pop;
   req_word_type    q_word;
   back_status_type stat;
   reg_index_type   csr_sel;
   logic            rsp_err;
   logic            rsp_quiet;

   assign pready  = 1'b1;
   assign csr_sel = reg_index_type'(paddr[2]);
   assign prdata  = (csr_sel == REG_QUANTUM) ? {24'd0, quantum_ff} : {28'd0, cap_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_ff <= QUANTUM_RST;
         cap_ff     <= CAP_RST;
      end else if (psel && penable && pwrite && pready) begin
         if (csr_sel == REG_QUANTUM) begin
            quantum_ff <= pwdata[7:0];
         end else begin
            cap_ff <= pwdata[3:0];
         end
      end
   end

   prras_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_word (req_word),
      .busy     (busy),
      .q_valid  (q_valid),
      .q_word   (q_word),
      .q_pop    (q_pop)
   );

   prras_back #(
      .MAX_TASKS   (MAX_TASKS),
      .BURST_WIDTH (BURST_WIDTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .quantum      (quantum_ff),
      .priority_cap (cap_ff),
      .q_valid      (q_valid),
      .q_word       (q_word),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_word     (rsp_word),
      .stat         (stat)
   );

   assign rsp_err   = rsp_valid && (rsp_word.status != ST_OK);
   assign rsp_quiet = (rsp_word.run_length == 8'd0) && !rsp_word.finished;

   `ASSERT_ALWAYS(a_no_overfill, clock, reset, !stat.overfull, "task table overfilled")
   `ASSERT_IMPLIES(a_pop_idle, clock, reset, q_pop, stat.idle && q_valid, "pop outside idle")
   `ASSERT_IMPLIES(a_err_quiet, clock, reset, rsp_err, rsp_quiet, "error result carries a run")

endmodule

/* tb/sv/tb_priority_round_robin_aging_scheduler.sv */
`timescale 1ns / 1ps

module tb_priority_round_robin_aging_scheduler;
   import prras_pkg::*;

   localparam int TASK_SLOTS  = 32;
   localparam int IDLE_LIMIT  = 20000;
   localparam int RANDOM_ADDS = 1000;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_word_type req_word;
   logic         rsp_valid;
   rsp_word_type rsp_word;
   logic         psel;
   logic         penable;
   logic         pwrite;
   logic [2:0]   paddr;
   logic [31:0]  pwdata;
   logic [31:0]  prdata;
   logic         pready;

   priority_round_robin_aging_scheduler DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_word(rsp_word), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // scheduler image
   logic [7:0]  img_id    [TASK_SLOTS];
   logic [3:0]  img_prio  [TASK_SLOTS];
   logic [15:0] img_burst [TASK_SLOTS];
   int          img_count;
   logic [7:0]  img_next_id;
   logic [31:0] img_time;
   logic [7:0]  cfg_quantum;
   logic [3:0]  cfg_cap;

   rsp_word_type expected_words[$];
   int           fail_count;
   int           idle_cycles;

   typedef struct {
      req_word_type req;
      logic         typed;
      rsp_word_type rsp;
   } stim_row_type;

   function automatic rsp_word_type schedule_word(req_word_type r);
      rsp_word_type o;
      int           best;
      logic [15:0]  b;
      logic [7:0]   run;
      logic [7:0]   id;
      o = '0;
      if (r.action == ACT_ADD) begin
         if (img_count >= TASK_SLOTS) begin
            o.status = ST_FULL;
         end else begin
            for (int i = img_count; i > 0; i--) begin
               img_id[i] = img_id[i-1];
               img_prio[i] = img_prio[i-1];
               img_burst[i] = img_burst[i-1];
            end
            img_id[0] = img_next_id;
            img_prio[0] = r.priority_req;
            img_burst[0] = r.burst;
            img_count++;
            o.task_id = img_next_id;
            img_next_id = img_next_id + 8'd1;
            o.status = ST_OK;
         end
      end else if (img_count == 0) begin
         o.status = ST_EMPTY;
      end else begin
         for (int i = 0; i < img_count; i++)
            if (img_prio[i] < cfg_cap) img_prio[i] = img_prio[i] + 4'd1;
         best = 0;
         for (int i = 1; i < img_count; i++)
            if (img_prio[i] > img_prio[best]) best = i;
         id = img_id[best];
         b = img_burst[best];
         run = (b < {8'd0, cfg_quantum}) ? b[7:0] : cfg_quantum;
         if ({1'b0, img_time} + run > 33'hFFFF_FFFF) img_time = 32'hFFFF_FFFF;
         else img_time = img_time + run;
         o.task_id = id;
         o.run_length = run;
         o.status = ST_OK;
         if (b > {8'd0, cfg_quantum}) begin
            for (int i = best; i > 0; i--) begin
               img_id[i] = img_id[i-1];
               img_prio[i] = img_prio[i-1];
               img_burst[i] = img_burst[i-1];
            end
            img_id[0] = id;
            img_prio[0] = REINS_PRIO;
            img_burst[0] = b - cfg_quantum;
         end else begin
            for (int i = best; i + 1 < img_count; i++) begin
               img_id[i] = img_id[i+1];
               img_prio[i] = img_prio[i+1];
               img_burst[i] = img_burst[i+1];
            end
            img_count--;
            o.finished = 1'b1;
         end
      end
      o.elapsed_time = img_time;
      return o;
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // result checker
   always @(posedge clock) begin
      rsp_word_type exp_w;
      if (!reset && rsp_valid) begin
         if (expected_words.size() == 0) begin
            $display("%0t: unexpected word %p", $time, rsp_word);
            fail_count++;
         end else begin
            exp_w = expected_words.pop_front();
            if (rsp_word !== exp_w) begin
               $display("%0t: mismatch expected %p actual %p", $time, exp_w, rsp_word);
               fail_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy) || psel) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic issue(req_word_type r, logic typed, rsp_word_type typed_rsp);
      rsp_word_type p;
      start <= 1'b1;
      req_word <= r;
      do @(posedge clock); while (busy);
      p = schedule_word(r);
      if (typed && p !== typed_rsp) begin
         $display("%0t: table row expected %p predicted %p", $time, typed_rsp, p);
         fail_count++;
      end
      expected_words.push_back(typed ? typed_rsp : p);
   endtask

   task automatic pause_sender(int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (TASK_SLOTS + 10) @(posedge clock);
   endtask

   task automatic write_reg(reg_index_type idx, logic [31:0] val);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= 3'(idx) << 2;
      pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (idx == REG_QUANTUM) cfg_quantum = val[7:0];
      else cfg_cap = val[3:0];
   endtask

   function automatic req_word_type mk(action_type a, logic [3:0] p, logic [15:0] b);
      req_word_type r;
      r.action = a;
      r.priority_req = p;
      r.burst = b;
      return r;
   endfunction

   function automatic rsp_word_type mr(logic [7:0] id, logic [7:0] run, logic fin,
                                       status_type st, logic [31:0] t);
      rsp_word_type o;
      o.task_id = id;
      o.run_length = run;
      o.finished = fin;
      o.status = st;
      o.elapsed_time = t;
      return o;
   endfunction

   task automatic random_phase(int n_items);
      int burst_left;
      int sent;
      req_word_type r;
      sent = 0;
      while (sent < n_items) begin
         burst_left = $urandom_range(1, 12);
         while (burst_left > 0 && sent < n_items) begin
            r.action = ($urandom_range(0, 99) < 48) ? ACT_ADD : ACT_PICK;
            r.priority_req = 4'($urandom);
            case ($urandom_range(0, 5))
               0: r.burst = 16'($urandom);
               1: r.burst = 16'hFFFF;
               2: r.burst = 16'd0;
               default: r.burst = 16'($urandom_range(1, 40));
            endcase
            issue(r, 1'b0, '0);
            burst_left--;
            sent++;
         end
         if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 50));
      end
      drain();
   endtask

   initial begin
      stim_row_type rows[$];
      reset = 1'b1;
      start = 1'b0;
      req_word = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      fail_count = 0;
      idle_cycles = 0;
      img_count = 0;
      img_next_id = '0;
      img_time = '0;
      cfg_quantum = QUANTUM_RST;
      cfg_cap = CAP_RST;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      rows.push_back('{mk(ACT_PICK, 4'd0, 16'd0), 1'b1,
                       mr(8'd0, 8'd0, 1'b0, ST_EMPTY, 32'd0)});
      rows.push_back('{mk(ACT_ADD, 4'd0, 16'd0), 1'b1,
                       mr(8'd0, 8'd0, 1'b0, ST_OK, 32'd0)});
      rows.push_back('{mk(ACT_PICK, 4'd0, 16'd0), 1'b1,
                       mr(8'd0, 8'd0, 1'b1, ST_OK, 32'd0)});
      rows.push_back('{mk(ACT_ADD, 4'd15, 16'hFFFF), 1'b1,
                       mr(8'd1, 8'd0, 1'b0, ST_OK, 32'd0)});
      rows.push_back('{mk(ACT_PICK, 4'd0, 16'd0), 1'b1,
                       mr(8'd1, 8'd10, 1'b0, ST_OK, 32'd10)});
      rows.push_back('{mk(ACT_ADD, 4'd3, 16'd5), 1'b0, '0});
      rows.push_back('{mk(ACT_ADD, 4'd3, 16'd7), 1'b0, '0});
      rows.push_back('{mk(ACT_ADD, 4'd9, 16'd10), 1'b0, '0});
      for (int i = 0; i < 6; i++) rows.push_back('{mk(ACT_PICK, 4'd0, 16'd0), 1'b0, '0});
      foreach (rows[i]) issue(rows[i].req, rows[i].typed, rows[i].rsp);
      drain();

      // fill past capacity
      for (int i = 0; i < TASK_SLOTS + 2; i++)
         issue(mk(ACT_ADD, 4'($urandom), 16'($urandom_range(1, 30))), 1'b0, '0);
      drain();
      random_phase(RANDOM_ADDS / 4);

      write_reg(REG_QUANTUM, 32'd255);
      write_reg(REG_CAP, 32'd15);
      random_phase(RANDOM_ADDS / 4);

      write_reg(REG_QUANTUM, 32'd0);
      write_reg(REG_CAP, 32'd0);
      random_phase(RANDOM_ADDS / 8);

      write_reg(REG_QUANTUM, 32'd1);
      write_reg(REG_CAP, 32'd1);
      random_phase(RANDOM_ADDS / 8);

      write_reg(REG_QUANTUM, 32'($urandom_range(2, 254)));
      write_reg(REG_CAP, 32'($urandom_range(2, 14)));
      random_phase(RANDOM_ADDS / 4);

      drain();
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/prras_pkg.sv
rtl/core/prras_front.sv
rtl/core/prras_back.sv
rtl/core/priority_round_robin_aging_scheduler.sv
tb/sv/tb_priority_round_robin_aging_scheduler.sv
